// ===== rtl/prid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prid_pkg
// Types and constants shared by the run-length image decoder modules.
// ----------------------------------------------------------------------------
package prid_pkg;

	localparam int unsigned PIXEL_W   = 20;
	localparam int unsigned CHANNEL_W = 2;
	localparam int unsigned VALUE_W   = 8;
	localparam int unsigned REPEAT_W  = 7;

	localparam logic [CHANNEL_W-1:0] LAST_CHANNEL = 2'd2;

	typedef struct packed {
		logic [PIXEL_W-1:0]   pixel;
		logic [CHANNEL_W-1:0] channel;
		logic [VALUE_W-1:0]   value;
		logic [REPEAT_W-1:0]  repeat_cnt;
		logic                 done;
		logic                 out_of_range;
	} result_t;

endpackage

// ===== rtl/planar_rle_image_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_rle_image_decoder_core
// Run-length image decoder: one compressed byte per transfer in, one pixel
// write descriptor (or image done marker) per transfer out.
//
// Channel  Direction  Handshake              Payload
// input    in         in_valid / in_ready    in_byte
// result   out        out_valid / out_ready  out_pixel, out_channel, out_value,
//                                            out_repeat, image_done, out_of_range
// config   in         cfg_we                 cfg_data (interleaved_rgb)
//
// One byte is accepted every cycle while in_ready is high; each descriptor is
// registered in the result register, or in the skid register while one waits.
// The decoder state is updated by a single layer of logic per byte.
// A two-entry output buffer lets input continue through one stalled result;
// in_ready drops only while both entries are full.
// Reset clears the decoder state and selects interleaved mode.
// ----------------------------------------------------------------------------
module planar_rle_image_decoder_core
	import prid_pkg::*;
#(
	parameter int unsigned MAX_PIXELS = 1048576
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [VALUE_W-1:0]   in_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PIXEL_W-1:0]   out_pixel,
	output logic [CHANNEL_W-1:0] out_channel,
	output logic [VALUE_W-1:0]   out_value,
	output logic [REPEAT_W-1:0]  out_repeat,
	output logic                 image_done,
	output logic                 out_of_range
);

	logic    interleaved_q;
	logic    accept;
	logic    res_valid;
	result_t res;
	result_t out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interleaved_q <= 1'b1;
		end else if (cfg_we) begin
			interleaved_q <= cfg_data;
		end
	end

	assign accept = in_valid && in_ready;

	prid_decode #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.in_byte        (in_byte),
		.interleaved_rgb(interleaved_q),
		.res_valid      (res_valid),
		.res            (res)
	);

	prid_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && res_valid),
		.push_data(res),
		.room     (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_res)
	);

	assign out_pixel    = out_res.pixel;
	assign out_channel  = out_res.channel;
	assign out_value    = out_res.value;
	assign out_repeat   = out_res.repeat_cnt;
	assign image_done   = out_res.done;
	assign out_of_range = out_res.out_of_range;

endmodule

// ===== rtl/prid_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prid_decode
// Header/run/literal sequencer that turns one compressed byte into at most one
// write descriptor and keeps the channel and pixel position of the image.
// ----------------------------------------------------------------------------
module prid_decode
	import prid_pkg::*;
#(
	parameter int unsigned MAX_PIXELS = 1048576
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    in_byte,
	input  logic          interleaved_rgb,
	output logic          res_valid,
	output result_t       res
);

	localparam int unsigned POS_W = $clog2(MAX_PIXELS + 1);
	localparam logic [POS_W:0] MAX_POS = (POS_W + 1)'(MAX_PIXELS);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_RUNVAL  = 2'd1;
	localparam logic [1:0] PH_LITERAL = 2'd2;

	logic [1:0]          phase_q, phase_d;
	logic [REPEAT_W-1:0] run_len_q, run_len_d;
	logic [REPEAT_W-1:0] lit_left_q, lit_left_d;
	logic [CHANNEL_W-1:0] chan_q, chan_d;
	logic [POS_W-1:0]    pos_q, pos_d;

	logic [REPEAT_W-1:0] count;
	logic [POS_W:0]      end_pos;
	logic                past_cap;
	logic [POS_W-1:0]    next_pos;
	result_t             write_res;

	assign count    = (phase_q == PH_RUNVAL) ? run_len_q : REPEAT_W'(1);
	assign end_pos  = {1'b0, pos_q} + (POS_W + 1)'(count);
	assign past_cap = end_pos > MAX_POS;
	assign next_pos = past_cap ? MAX_POS[POS_W-1:0] : end_pos[POS_W-1:0];

	always_comb begin
		write_res              = '0;
		write_res.pixel        = PIXEL_W'(pos_q);
		write_res.channel      = interleaved_rgb ? chan_q : '0;
		write_res.value        = in_byte;
		write_res.repeat_cnt   = count;
		write_res.out_of_range = past_cap;
	end

	always_comb begin
		phase_d    = phase_q;
		run_len_d  = run_len_q;
		lit_left_d = lit_left_q;
		chan_d     = chan_q;
		pos_d      = pos_q;
		res_valid  = 1'b0;
		res        = write_res;
		unique case (phase_q)
			PH_RUNVAL: begin
				res_valid = 1'b1;
				pos_d     = next_pos;
				run_len_d = '0;
				phase_d   = PH_HEADER;
			end
			PH_LITERAL: begin
				res_valid  = 1'b1;
				pos_d      = next_pos;
				lit_left_d = lit_left_q - REPEAT_W'(1);
				if (lit_left_d == '0) begin
					phase_d = PH_HEADER;
				end
			end
			default: begin
				phase_d = PH_HEADER;
				if (in_byte == 8'd0) begin
					if (interleaved_rgb && (chan_q < LAST_CHANNEL)) begin
						chan_d = chan_q + CHANNEL_W'(1);
						pos_d  = '0;
					end else begin
						res_valid  = 1'b1;
						res        = '0;
						res.done   = 1'b1;
						run_len_d  = '0;
						lit_left_d = '0;
						chan_d     = '0;
						pos_d      = '0;
					end
				end else if (!in_byte[7]) begin
					run_len_d = in_byte[6:0];
					phase_d   = PH_RUNVAL;
				end else begin
					lit_left_d = in_byte[6:0];
					if (in_byte[6:0] != '0) begin
						phase_d = PH_LITERAL;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			run_len_q  <= '0;
			lit_left_q <= '0;
			chan_q     <= '0;
			pos_q      <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			run_len_q  <= run_len_d;
			lit_left_q <= lit_left_d;
			chan_q     <= chan_d;
			pos_q      <= pos_d;
		end
	end

	// The position saturates at the capacity and never passes it.
	a_pos_capped: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} <= MAX_POS)
		else $error("pixel position beyond capacity");

	// The channel counter never goes past LAST_CHANNEL.
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		chan_q <= LAST_CHANNEL)
		else $error("channel index out of range");

	// A done result leaves the decoder at the start of a fresh image.
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_valid && res.done |=>
			phase_q == PH_HEADER && chan_q == '0 && pos_q == '0)
		else $error("image state not cleared after done");

endmodule

// ===== rtl/prid_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prid_skid
// Two-entry output buffer: a result register backed by a skid register, so
// the decoder keeps accepting while a result waits for its transfer.
// ----------------------------------------------------------------------------
module prid_skid
	import prid_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;

	assign room      = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for planar_rle_image_decoder_core. A driver feeds the
// compressed byte stream with random gaps, and a behavioral decoder predicts
// the write descriptors that the input transfers produce. A monitor with random
// stalls checks every output transfer against the oldest prediction. Phases
// cover both channel modes, a mode change in mid-image and a long output
// stall.
// ----------------------------------------------------------------------------
module testbench;
	import prid_pkg::*;

	localparam int unsigned CAPACITY = 1048576;
	localparam int unsigned RUN_MAX = 127;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned FINAL_CYCLES = 20;
	localparam int unsigned LONG_HOLD_CYCLES = 400;
	localparam int unsigned PHASE_BYTES = 100;
	localparam int unsigned MAX_REPORTS = 40;
	localparam logic [VALUE_W-1:0] END_OF_CHANNEL = 8'h00;
	localparam logic [VALUE_W-1:0] LITERAL_BASE = 8'h80;
	localparam logic MODE_SINGLE = 1'b0;
	localparam logic MODE_RGB = 1'b1;

	typedef enum logic [1:0] {
		EXPECT_HEADER,
		EXPECT_RUN_VALUE,
		EXPECT_LITERAL
	} decode_phase_e;

	localparam logic [VALUE_W-1:0] OPENING_BYTES [17] = '{
		8'h01, 8'h00,
		8'h7F, 8'hFF,
		LITERAL_BASE | 8'd3, 8'h00, 8'hFF, 8'h5A,
		LITERAL_BASE,
		END_OF_CHANNEL,
		8'h05, 8'hA5,
		END_OF_CHANNEL,
		LITERAL_BASE | 8'd1, 8'h7E,
		END_OF_CHANNEL,
		8'h40
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic                 cfg_data = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [VALUE_W-1:0]   in_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [PIXEL_W-1:0]   out_pixel;
	logic [CHANNEL_W-1:0] out_channel;
	logic [VALUE_W-1:0]   out_value;
	logic [REPEAT_W-1:0]  out_repeat;
	logic                 image_done;
	logic                 out_of_range;

	logic [VALUE_W-1:0] stream_q[$];
	result_t            write_q[$];

	logic                 rgb_mode = MODE_RGB;
	decode_phase_e        dec_phase = EXPECT_HEADER;
	logic [REPEAT_W-1:0]  run_len = '0;
	logic [REPEAT_W-1:0]  literals_left = '0;
	logic [CHANNEL_W-1:0] chan_idx = '0;
	logic [20:0]          pix_pos = '0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_req = 0;
	int unsigned hold_ack = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatch_count = 0;

	planar_rle_image_decoder_core #(
		.MAX_PIXELS(CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_pixel(out_pixel),
		.out_channel(out_channel),
		.out_value(out_value),
		.out_repeat(out_repeat),
		.image_done(image_done),
		.out_of_range(out_of_range)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("MISMATCH at %0t: %s", $time, what);
		end
	endtask

	task automatic add_write(input logic [VALUE_W-1:0] value, input logic [REPEAT_W-1:0] count);
		result_t     r;
		logic [21:0] end_pos;
		end_pos = pix_pos + count;
		r.pixel = pix_pos[PIXEL_W-1:0];
		r.channel = rgb_mode ? chan_idx : '0;
		r.value = value;
		r.repeat_cnt = count;
		r.done = 1'b0;
		r.out_of_range = (end_pos > CAPACITY);
		pix_pos = r.out_of_range ? 21'(CAPACITY) : end_pos[20:0];
		write_q.push_back(r);
	endtask

	task automatic decode_byte(input logic [VALUE_W-1:0] b);
		result_t r;
		case (dec_phase)
			EXPECT_RUN_VALUE: begin
				add_write(b, run_len);
				run_len = '0;
				dec_phase = EXPECT_HEADER;
			end
			EXPECT_LITERAL: begin
				add_write(b, 7'd1);
				literals_left = literals_left - 1'b1;
				if (literals_left == '0) begin
					dec_phase = EXPECT_HEADER;
				end
			end
			default: begin
				dec_phase = EXPECT_HEADER;
				if (b == END_OF_CHANNEL) begin
					if (rgb_mode && chan_idx < LAST_CHANNEL) begin
						chan_idx = chan_idx + 1'b1;
						pix_pos = '0;
					end else begin
						r = '0;
						r.done = 1'b1;
						write_q.push_back(r);
						run_len = '0;
						literals_left = '0;
						chan_idx = '0;
						pix_pos = '0;
					end
				end else if (b < LITERAL_BASE) begin
					run_len = b[REPEAT_W-1:0];
					dec_phase = EXPECT_RUN_VALUE;
				end else begin
					literals_left = b[REPEAT_W-1:0];
					if (literals_left != '0) begin
						dec_phase = EXPECT_LITERAL;
					end
				end
			end
		endcase
	endtask

	task automatic check_write();
		result_t want;
		if (write_q.size() == 0) begin
			report_mismatch("output transfer with no descriptor pending");
		end else begin
			want = write_q.pop_front();
			if (out_pixel !== want.pixel)
				report_mismatch($sformatf("out_pixel %0d, expected %0d", out_pixel, want.pixel));
			if (out_channel !== want.channel)
				report_mismatch($sformatf("out_channel %0d, expected %0d", out_channel,
					want.channel));
			if (out_value !== want.value)
				report_mismatch($sformatf("out_value %0d, expected %0d", out_value, want.value));
			if (out_repeat !== want.repeat_cnt)
				report_mismatch($sformatf("out_repeat %0d, expected %0d", out_repeat,
					want.repeat_cnt));
			if (image_done !== want.done)
				report_mismatch($sformatf("image_done %0b, expected %0b", image_done, want.done));
			if (out_of_range !== want.out_of_range)
				report_mismatch($sformatf("out_of_range %0b, expected %0b", out_of_range,
					want.out_of_range));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				decode_byte(in_byte);
			end
			if (!in_valid || in_ready) begin
				if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_byte <= stream_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				check_write();
			end
			if (hold_ack != hold_req) begin
				hold_ack <= hold_req;
				hold_left <= LONG_HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && !((in_valid && in_ready) || (out_valid && out_ready))) begin
			quiet_cycles <= quiet_cycles + 1;
		end else begin
			quiet_cycles <= 0;
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk);
		$display("planar_rle_image_decoder_core regression: fail");
		$finish;
	end

	task automatic wait_for_drain();
		do @(negedge clk); while (stream_q.size() != 0 || in_valid || write_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input logic mode);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		rgb_mode = mode;
	endtask

	task automatic queue_image();
		int unsigned         n_chan;
		int unsigned         seg_cnt;
		int unsigned         lit_cnt;
		logic [VALUE_W-1:0]  hdr;
		n_chan = rgb_mode ? int'(LAST_CHANNEL) + 1 : 1;
		for (int c = 0; c < n_chan; c++) begin
			seg_cnt = $urandom_range(4);
			for (int s = 0; s < seg_cnt; s++) begin
				if ($urandom_range(9) == 0) begin
					stream_q.push_back(VALUE_W'($urandom_range(255)));
				end
				if ($urandom_range(1) == 1) begin
					case ($urandom_range(3))
						0: hdr = 8'd1;
						1: hdr = VALUE_W'(RUN_MAX);
						default: hdr = VALUE_W'($urandom_range(RUN_MAX, 1));
					endcase
					stream_q.push_back(hdr);
					stream_q.push_back(VALUE_W'($urandom_range(255)));
				end else begin
					lit_cnt = ($urandom_range(11) == 0) ? $urandom_range(RUN_MAX) : $urandom_range(4);
					stream_q.push_back(LITERAL_BASE | VALUE_W'(lit_cnt));
					repeat (lit_cnt) stream_q.push_back(VALUE_W'($urandom_range(255)));
				end
			end
			stream_q.push_back(END_OF_CHANNEL);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		foreach (OPENING_BYTES[i]) stream_q.push_back(OPENING_BYTES[i]);
		stream_q.push_back(8'hC4);
		wait_for_drain();

		write_mode(MODE_SINGLE);
		@(negedge clk);
		stream_q.push_back(END_OF_CHANNEL);
		stream_q.push_back(8'h02);
		stream_q.push_back(8'h11);
		stream_q.push_back(END_OF_CHANNEL);
		wait_for_drain();

		// Channel mode flips while an image is half decoded.
		write_mode(MODE_RGB);
		@(negedge clk);
		stream_q.push_back(8'h03);
		stream_q.push_back(8'h22);
		stream_q.push_back(END_OF_CHANNEL);
		wait_for_drain();
		write_mode(MODE_SINGLE);
		@(negedge clk);
		stream_q.push_back(8'h04);
		stream_q.push_back(8'h33);
		stream_q.push_back(END_OF_CHANNEL);
		wait_for_drain();

		for (int p = 0; p < 4; p++) begin
			write_mode((p % 2 == 0) ? MODE_RGB : MODE_SINGLE);
			@(negedge clk);
			case (p)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					hold_req++;
				end
				1: begin
					send_idle_pct = 55;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 55;
				end
				default: begin
					send_idle_pct = 8;
					recv_stall_pct = 8;
				end
			endcase
			while (stream_q.size() < PHASE_BYTES) queue_image();
			wait_for_drain();
		end

		repeat (FINAL_CYCLES) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("planar_rle_image_decoder_core regression: pass");
		end else begin
			$display("planar_rle_image_decoder_core regression: fail");
		end
		$finish;
	end

endmodule
